FILE: design/lpg_pkg.sv
// Shared constants, command and status types for the lexicographic permutation generator.
// No dependencies; the controller, datapath, top level and checker refer to it by scoped names.

package lpg_pkg;

    localparam int MAX_ELEMENTS = 8;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = 4;
    localparam int VAL_W        = 3;

    localparam logic [CNT_W-1:0] COUNT_RESET = 4'd4;

    // Commands from the controller to the datapath, one strobe per step
    typedef struct packed {
        logic accept;   // item taken this cycle; restart reloads identity
        logic find;     // snapshot result, locate rightmost ascent
        logic pivot;    // read pivot entry
        logic search;   // locate rightmost larger entry, set suffix bounds
        logic swap;     // swap pivot with larger entry
        logic rev_a;    // read left suffix entry
        logic rev_b;    // swap left and right suffix entries, move bounds
        logic push;     // move staged result into the output register
    } cmd_t;

    typedef struct packed {
        logic no_ascent;  // current ordering fully descending
        logic rev_start;  // suffix has at least one pair to swap
        logic rev_more;   // another pair remains after this one
    } status_t;

endpackage

FILE: design/lpg_ctrl.sv
// Sequencing state machine for the permutation generator.
// Depends on lpg_pkg for the command and status types.

module lpg_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  lpg_pkg::status_t  status,
    output lpg_pkg::cmd_t     cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_FIND   = 8'b0000_0010,
        S_PIVOT  = 8'b0000_0100,
        S_SEARCH = 8'b0000_1000,
        S_SWAP   = 8'b0001_0000,
        S_REV_A  = 8'b0010_0000,
        S_REV_B  = 8'b0100_0000,
        S_PUSH   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;

        // drop the held beat once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = status.no_ascent ? S_PUSH : S_PIVOT;
            end
            S_PIVOT:
            begin
                cmd.pivot  = 1'b1;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = S_SWAP;
            end
            S_SWAP:
            begin
                cmd.swap   = 1'b1;
                state_next = status.rev_start ? S_REV_A : S_PUSH;
            end
            S_REV_A:
            begin
                cmd.rev_a  = 1'b1;
                state_next = S_REV_B;
            end
            S_REV_B:
            begin
                cmd.rev_b  = 1'b1;
                state_next = status.rev_more ? S_REV_A : S_PUSH;
            end
            S_PUSH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.push       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/lpg_datapath.sv
// Ordering registers, index registers and result registers for the permutation generator.
// Depends on lpg_pkg; driven by the command strobes of lpg_ctrl.

module lpg_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [lpg_pkg::CNT_W-1:0]             cfg_count,
    input  logic                                  restart,
    input  lpg_pkg::cmd_t                         cmd,
    output lpg_pkg::status_t                      status,
    output logic [lpg_pkg::VAL_W-1:0]             slot_out [lpg_pkg::MAX_ELEMENTS],
    output logic                                  final_out
);

    logic [lpg_pkg::CNT_W-1:0] count_reg;
    logic [lpg_pkg::CNT_W-1:0] n_eff;
    logic [lpg_pkg::IDX_W-1:0] n_last;

    logic [lpg_pkg::VAL_W-1:0] order_reg  [lpg_pkg::MAX_ELEMENTS];
    logic [lpg_pkg::VAL_W-1:0] order_next [lpg_pkg::MAX_ELEMENTS];

    logic [lpg_pkg::IDX_W-1:0] i_reg;
    logic [lpg_pkg::IDX_W-1:0] j_reg;
    logic [lpg_pkg::IDX_W-1:0] l_reg;
    logic [lpg_pkg::IDX_W-1:0] r_reg;
    logic [lpg_pkg::VAL_W-1:0] pivot_reg;
    logic [lpg_pkg::VAL_W-1:0] tmp_reg;

    logic [lpg_pkg::VAL_W-1:0] stage_reg [lpg_pkg::MAX_ELEMENTS];
    logic                      stage_final_reg;
    logic [lpg_pkg::VAL_W-1:0] out_reg   [lpg_pkg::MAX_ELEMENTS];
    logic                      out_final_reg;

    logic                      asc_found;
    logic [lpg_pkg::IDX_W-1:0] asc_idx;
    logic [lpg_pkg::IDX_W-1:0] gt_idx;
    logic [lpg_pkg::IDX_W-1:0] rd_addr;
    logic [lpg_pkg::VAL_W-1:0] rd_data;
    logic                      load_id;

    // zero acts as one, anything above the maximum acts as the maximum
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = lpg_pkg::CNT_W'(1);
        end
        else if (count_reg > lpg_pkg::CNT_W'(lpg_pkg::MAX_ELEMENTS))
        begin
            n_eff = lpg_pkg::CNT_W'(lpg_pkg::MAX_ELEMENTS);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    assign n_last = lpg_pkg::IDX_W'(n_eff - lpg_pkg::CNT_W'(1));

    // rightmost ascent among the first n entries
    always_comb
    begin
        asc_found = 1'b0;
        asc_idx   = '0;
        for (int k = 0; k < lpg_pkg::MAX_ELEMENTS - 1; k++)
        begin
            if ((lpg_pkg::CNT_W'(k + 2) <= n_eff) && (order_reg[k] < order_reg[k + 1]))
            begin
                asc_found = 1'b1;
                asc_idx   = lpg_pkg::IDX_W'(k);
            end
        end
    end

    // rightmost entry right of the pivot that is larger than it
    always_comb
    begin
        gt_idx = '0;
        for (int k = 1; k < lpg_pkg::MAX_ELEMENTS; k++)
        begin
            if ((lpg_pkg::IDX_W'(k) > i_reg) && (lpg_pkg::CNT_W'(k) < n_eff)
                && (order_reg[k] > pivot_reg))
            begin
                gt_idx = lpg_pkg::IDX_W'(k);
            end
        end
    end

    // single read port
    always_comb
    begin
        rd_addr = i_reg;
        if (cmd.swap)
        begin
            rd_addr = j_reg;
        end
        else if (cmd.rev_a)
        begin
            rd_addr = l_reg;
        end
        else if (cmd.rev_b)
        begin
            rd_addr = r_reg;
        end
    end

    assign rd_data = order_reg[rd_addr];

    assign load_id = (cmd.accept && restart) || (cmd.find && !asc_found);

    assign status.no_ascent = !asc_found;
    assign status.rev_start = (l_reg < r_reg);
    assign status.rev_more  = (({1'b0, l_reg} + 4'd3) <= {1'b0, r_reg});

    always_comb
    begin
        for (int k = 0; k < lpg_pkg::MAX_ELEMENTS; k++)
        begin
            order_next[k] = order_reg[k];
        end
        if (load_id)
        begin
            for (int k = 0; k < lpg_pkg::MAX_ELEMENTS; k++)
            begin
                order_next[k] = lpg_pkg::VAL_W'(k);
            end
        end
        else if (cmd.swap)
        begin
            order_next[i_reg] = rd_data;
            order_next[j_reg] = pivot_reg;
        end
        else if (cmd.rev_b)
        begin
            order_next[l_reg] = rd_data;
            order_next[r_reg] = tmp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= lpg_pkg::COUNT_RESET;
            for (int k = 0; k < lpg_pkg::MAX_ELEMENTS; k++)
            begin
                order_reg[k] <= lpg_pkg::VAL_W'(k);
            end
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_count;
            end
            for (int k = 0; k < lpg_pkg::MAX_ELEMENTS; k++)
            begin
                order_reg[k] <= order_next[k];
            end
        end
    end

    // working and result registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.find)
        begin
            i_reg           <= asc_idx;
            stage_final_reg <= !asc_found;
            for (int k = 0; k < lpg_pkg::MAX_ELEMENTS; k++)
            begin
                stage_reg[k] <= (lpg_pkg::CNT_W'(k) < n_eff) ? order_reg[k] : '0;
            end
        end
        if (cmd.pivot)
        begin
            pivot_reg <= rd_data;
        end
        if (cmd.search)
        begin
            j_reg <= gt_idx;
            l_reg <= i_reg + lpg_pkg::IDX_W'(1);
            r_reg <= n_last;
        end
        if (cmd.rev_a)
        begin
            tmp_reg <= rd_data;
        end
        if (cmd.rev_b)
        begin
            l_reg <= l_reg + lpg_pkg::IDX_W'(1);
            r_reg <= r_reg - lpg_pkg::IDX_W'(1);
        end
        if (cmd.push)
        begin
            out_final_reg <= stage_final_reg;
            for (int k = 0; k < lpg_pkg::MAX_ELEMENTS; k++)
            begin
                out_reg[k] <= stage_reg[k];
            end
        end
    end

    assign final_out = out_final_reg;

    always_comb
    begin
        for (int k = 0; k < lpg_pkg::MAX_ELEMENTS; k++)
        begin
            slot_out[k] = out_reg[k];
        end
    end

endmodule

FILE: design/lexicographic_permutation_generator.sv
// Channel   | Handshake            | Payload
// in        | in_valid / in_stall  | restart
// out       | out_valid / out_stall| slot_0_value .. slot_7_value, final_flag
// cfg       | cfg_valid / cfg_ready| cfg_data (element_count)
//
// After acceptance, an item whose ordering wraps goes from the find step straight to push;
// else find, pivot, search, swap, then a read and a swap for each of floor((n - i - 1) / 2)
// suffix pairs, i the rightmost ascent, then push, which waits while a held result is stalled.
// The pivot, swap and suffix reversal steps share the single read port, one entry at a time.
// Reset loads the identity ordering and an element count of four; no clearing pass.
// A stalled result is held in the output register while the next item is being worked.
// Top level: joins lpg_ctrl and lpg_datapath; depends on lpg_pkg.

module lexicographic_permutation_generator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          restart,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lpg_pkg::VAL_W-1:0]     slot_0_value,
    output logic [lpg_pkg::VAL_W-1:0]     slot_1_value,
    output logic [lpg_pkg::VAL_W-1:0]     slot_2_value,
    output logic [lpg_pkg::VAL_W-1:0]     slot_3_value,
    output logic [lpg_pkg::VAL_W-1:0]     slot_4_value,
    output logic [lpg_pkg::VAL_W-1:0]     slot_5_value,
    output logic [lpg_pkg::VAL_W-1:0]     slot_6_value,
    output logic [lpg_pkg::VAL_W-1:0]     slot_7_value,
    output logic                          final_flag,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lpg_pkg::CNT_W-1:0]     cfg_data
);

    lpg_pkg::cmd_t            cmd;
    lpg_pkg::status_t         status;
    logic [lpg_pkg::VAL_W-1:0] slot [lpg_pkg::MAX_ELEMENTS];

    assign cfg_ready = 1'b1;

    lpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lpg_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_count (cfg_data),
        .restart   (restart),
        .cmd       (cmd),
        .status    (status),
        .slot_out  (slot),
        .final_out (final_flag)
    );

    assign slot_0_value = slot[0];
    assign slot_1_value = slot[1];
    assign slot_2_value = slot[2];
    assign slot_3_value = slot[3];
    assign slot_4_value = slot[4];
    assign slot_5_value = slot[5];
    assign slot_6_value = slot[6];
    assign slot_7_value = slot[7];

endmodule

FILE: design/lpg_checker.sv
// Port-level checks for the permutation generator, bound to the top level.
// Depends on lpg_pkg for field widths.

module lpg_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [lpg_pkg::VAL_W-1:0]     slot_0_value,
    input logic [lpg_pkg::VAL_W-1:0]     slot_1_value,
    input logic [lpg_pkg::VAL_W-1:0]     slot_2_value,
    input logic [lpg_pkg::VAL_W-1:0]     slot_3_value,
    input logic [lpg_pkg::VAL_W-1:0]     slot_4_value,
    input logic [lpg_pkg::VAL_W-1:0]     slot_5_value,
    input logic [lpg_pkg::VAL_W-1:0]     slot_6_value,
    input logic [lpg_pkg::VAL_W-1:0]     slot_7_value,
    input logic                          final_flag
);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(final_flag) && $stable(slot_0_value)
            && $stable(slot_7_value))
        else $error("stalled result changed");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again before the item was worked");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in work");

    // the last ordering is fully descending, unused slots read zero
    a_final_descending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && final_flag |->
            (slot_0_value >= slot_1_value) && (slot_1_value >= slot_2_value)
            && (slot_2_value >= slot_3_value) && (slot_3_value >= slot_4_value)
            && (slot_4_value >= slot_5_value) && (slot_5_value >= slot_6_value)
            && (slot_6_value >= slot_7_value))
        else $error("final flag on an ordering with an ascent");

endmodule

bind lexicographic_permutation_generator lpg_checker u_lpg_checker (.*);
